>>> rtl/core/s5cp_pkg.sv
// Shared types, codes and constants of the SOCKS5 connect message parser.
package s5cp_pkg;

  // Protocol constants.
  localparam logic [7:0] SocksVersion  = 8'h05;
  localparam logic [7:0] ReservedValue = 8'h00;
  localparam logic [7:0] AtypIpv4      = 8'h01;
  localparam logic [7:0] AtypDomain    = 8'h03;
  localparam logic [7:0] AtypIpv6      = 8'h04;

  // Address lengths for the fixed-size address types.
  localparam logic [8:0] Ipv4Length = 9'd4;
  localparam logic [8:0] Ipv6Length = 9'd16;

  // Byte count at the first address byte.
  localparam logic [8:0] AddrStartFixed  = 9'd4;
  localparam logic [8:0] AddrStartDomain = 9'd5;

  // Values of the parse_status field.
  localparam logic [1:0] StatusMore     = 2'd0;
  localparam logic [1:0] StatusComplete = 2'd1;
  localparam logic [1:0] StatusError    = 2'd2;

  // Values of the error_kind field.
  localparam logic [1:0] ErrVersion  = 2'd0;
  localparam logic [1:0] ErrReserved = 2'd1;
  localparam logic [1:0] ErrAddrType = 2'd2;
  localparam logic [1:0] ErrEmptyDom = 2'd3;

  // Values of the address_kind field.
  localparam logic [1:0] KindIpv4   = 2'd0;
  localparam logic [1:0] KindDomain = 2'd1;
  localparam logic [1:0] KindIpv6   = 2'd2;

  // Smallest complete message: header, one-byte domain with its length, port.
  localparam logic [8:0] MinMessageLength = 9'd8;

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhDlen   = 3'd1,
    PhAddr   = 3'd2,
    PhPortHi = 3'd3,
    PhPortLo = 3'd4
  } phase_e;

  typedef struct packed {
    logic [1:0]  parse_status;
    logic [1:0]  error_kind;
    logic [7:0]  command_code;
    logic [1:0]  address_kind;
    logic [7:0]  host_byte;
    logic        host_byte_valid;
    logic [7:0]  host_byte_index;
    logic [15:0] dest_port;
    logic [8:0]  message_length;
  } result_t;

endpackage

>>> rtl/core/s5cp_in_if.sv
// Byte input channel of the SOCKS5 connect message parser.
interface s5cp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

>>> rtl/core/s5cp_out_if.sv
// Result channel of the SOCKS5 connect message parser.
interface s5cp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  parse_status;
  logic [1:0]  error_kind;
  logic [7:0]  command_code;
  logic [1:0]  address_kind;
  logic [7:0]  host_byte;
  logic        host_byte_valid;
  logic [7:0]  host_byte_index;
  logic [15:0] dest_port;
  logic [8:0]  message_length;

  modport source (
    output valid, output parse_status, output error_kind, output command_code,
    output address_kind, output host_byte, output host_byte_valid,
    output host_byte_index, output dest_port, output message_length,
    input ready
  );
  modport sink (
    input valid, input parse_status, input error_kind, input command_code,
    input address_kind, input host_byte, input host_byte_valid,
    input host_byte_index, input dest_port, input message_length,
    output ready
  );
endinterface

>>> rtl/core/s5cp_in_stage.sv
// Input register of the parser: holds one accepted byte until it is processed.
module s5cp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  s5cp_in_if.sink    in_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] data_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       take;

  // The register frees up in the same cycle that its byte moves on.
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (take) begin
      valid_d = 1'b1;
      data_d  = in_i.data_byte;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o     = valid_q;
  assign data_byte_o = data_q;

endmodule

>>> rtl/core/s5cp_step.sv
// Parser state and the per-byte update that produces one result.
module s5cp_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           data_byte_i,
  output s5cp_pkg::result_t    result_o
);

  s5cp_pkg::phase_e phase_q, phase_d;
  logic [8:0] count_q, count_d;
  logic [7:0] version_q, version_d;
  logic [7:0] command_q, command_d;
  logic [7:0] reserved_q, reserved_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] dom_len_q, dom_len_d;
  logic [7:0] port_hi_q, port_hi_d;

  logic [1:0] hdr_idx;
  logic [8:0] addr_start;
  logic [8:0] addr_offset;
  logic [8:0] addr_len;
  logic [8:0] count_inc;
  s5cp_pkg::result_t res;

  // A header count beyond the fourth byte starts the header afresh.
  assign hdr_idx     = (count_q > 9'd3) ? 2'd0 : count_q[1:0];
  assign addr_start  = (kind_q == s5cp_pkg::KindDomain) ? s5cp_pkg::AddrStartDomain
                                                        : s5cp_pkg::AddrStartFixed;
  assign addr_offset = count_q - addr_start;
  assign count_inc   = count_q + 9'd1;

  always_comb begin
    case (kind_q)
      s5cp_pkg::KindIpv4: addr_len = s5cp_pkg::Ipv4Length;
      s5cp_pkg::KindIpv6: addr_len = s5cp_pkg::Ipv6Length;
      default:            addr_len = {1'b0, dom_len_q};
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    version_d  = version_q;
    command_d  = command_q;
    reserved_d = reserved_q;
    kind_d     = kind_q;
    dom_len_d  = dom_len_q;
    port_hi_d  = port_hi_q;
    res        = '0;
    res.parse_status = s5cp_pkg::StatusMore;

    unique case (phase_q)
      s5cp_pkg::PhHeader: begin
        case (hdr_idx)
          2'd0: begin
            version_d = data_byte_i;
            count_d   = 9'd1;
          end
          2'd1: begin
            command_d = data_byte_i;
            count_d   = 9'd2;
          end
          2'd2: begin
            reserved_d = data_byte_i;
            count_d    = 9'd3;
          end
          default: begin
            count_d = 9'd0;
            if (version_q != s5cp_pkg::SocksVersion) begin
              res.parse_status = s5cp_pkg::StatusError;
              res.error_kind   = s5cp_pkg::ErrVersion;
            end else if (reserved_q != s5cp_pkg::ReservedValue) begin
              res.parse_status = s5cp_pkg::StatusError;
              res.error_kind   = s5cp_pkg::ErrReserved;
            end else if (data_byte_i == s5cp_pkg::AtypIpv4) begin
              kind_d  = s5cp_pkg::KindIpv4;
              phase_d = s5cp_pkg::PhAddr;
              count_d = 9'd4;
            end else if (data_byte_i == s5cp_pkg::AtypDomain) begin
              kind_d  = s5cp_pkg::KindDomain;
              phase_d = s5cp_pkg::PhDlen;
              count_d = 9'd4;
            end else if (data_byte_i == s5cp_pkg::AtypIpv6) begin
              kind_d  = s5cp_pkg::KindIpv6;
              phase_d = s5cp_pkg::PhAddr;
              count_d = 9'd4;
            end else begin
              res.parse_status = s5cp_pkg::StatusError;
              res.error_kind   = s5cp_pkg::ErrAddrType;
            end
          end
        endcase
      end
      s5cp_pkg::PhDlen: begin
        if (data_byte_i == 8'd0) begin
          res.parse_status = s5cp_pkg::StatusError;
          res.error_kind   = s5cp_pkg::ErrEmptyDom;
          phase_d          = s5cp_pkg::PhHeader;
          count_d          = 9'd0;
        end else begin
          dom_len_d = data_byte_i;
          phase_d   = s5cp_pkg::PhAddr;
          count_d   = 9'd5;
        end
      end
      s5cp_pkg::PhAddr: begin
        res.host_byte       = data_byte_i;
        res.host_byte_valid = 1'b1;
        res.host_byte_index = addr_offset[7:0];
        count_d             = count_inc;
        if ({1'b0, addr_offset[7:0]} + 9'd1 >= addr_len) begin
          phase_d = s5cp_pkg::PhPortHi;
        end
      end
      s5cp_pkg::PhPortHi: begin
        port_hi_d = data_byte_i;
        count_d   = count_inc;
        phase_d   = s5cp_pkg::PhPortLo;
      end
      s5cp_pkg::PhPortLo: begin
        res.parse_status   = s5cp_pkg::StatusComplete;
        res.command_code   = command_q;
        res.address_kind   = kind_q;
        res.dest_port      = {port_hi_q, data_byte_i};
        res.message_length = count_inc;
        phase_d            = s5cp_pkg::PhHeader;
        count_d            = 9'd0;
      end
      default: begin
        // Unused phase code: behave as a fresh header byte.
        version_d = data_byte_i;
        phase_d   = s5cp_pkg::PhHeader;
        count_d   = 9'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= s5cp_pkg::PhHeader;
      count_q    <= '0;
      version_q  <= '0;
      command_q  <= '0;
      reserved_q <= '0;
      kind_q     <= '0;
      dom_len_q  <= '0;
      port_hi_q  <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      version_q  <= version_d;
      command_q  <= command_d;
      reserved_q <= reserved_d;
      kind_q     <= kind_d;
      dom_len_q  <= dom_len_d;
      port_hi_q  <= port_hi_d;
    end
  end

  assign result_o = res;

endmodule

>>> rtl/core/s5cp_out_stage.sv
// Result register of the parser, driving the result channel.
module s5cp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_valid_i,
  input  s5cp_pkg::result_t  result_i,
  output logic               space_o,
  s5cp_out_if.source         out_o
);

  logic              valid_q, valid_d;
  s5cp_pkg::result_t res_q, res_d;
  logic              load;

  // A waiting result that is taken this cycle makes room for the next one.
  assign space_o = !valid_q || out_o.ready;
  assign load    = load_valid_i && space_o;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load) begin
      valid_d = 1'b1;
      res_d   = result_i;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid           = valid_q;
  assign out_o.parse_status    = res_q.parse_status;
  assign out_o.error_kind      = res_q.error_kind;
  assign out_o.command_code    = res_q.command_code;
  assign out_o.address_kind    = res_q.address_kind;
  assign out_o.host_byte       = res_q.host_byte;
  assign out_o.host_byte_valid = res_q.host_byte_valid;
  assign out_o.host_byte_index = res_q.host_byte_index;
  assign out_o.dest_port       = res_q.dest_port;
  assign out_o.message_length  = res_q.message_length;

endmodule

>>> rtl/core/socks5_connect_message_parser.sv
// Top level of the SOCKS5 connect message parser.
//
//   Channel  Direction  Beat carries
//   in_i     input      one byte of the request or reply stream (data_byte)
//   out_o    output     one result per byte: status, error, command, address
//                       kind, host byte with its index, port and length
//
// Every accepted input beat yields exactly one result beat, one byte per cycle
// sustained while out_o is ready. A byte waits in the input register until the
// result register has room; then the parser state and the result register
// update together to offer its result. Reset is asynchronous and active low and
// restarts the parser at the first header byte, with no clearing pass after it.
// A result that is not taken holds the input byte; input ready falls once both are full.
module socks5_connect_message_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  s5cp_in_if.sink     in_i,
  s5cp_out_if.source  out_o
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_space;
  logic              advance;
  s5cp_pkg::result_t step_result;

  // The held byte is processed in the cycle that the result register can take
  // its result; the parser state moves on only then.
  assign advance = in_valid && out_space;

  s5cp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .advance_i   (advance),
    .valid_o     (in_valid),
    .data_byte_o (in_byte)
  );

  s5cp_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .data_byte_i (in_byte),
    .result_o    (step_result)
  );

  s5cp_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (in_valid),
    .result_i     (step_result),
    .space_o      (out_space),
    .out_o        (out_o)
  );

`ifndef NO_ASSERTIONS
  // An address byte is only ever passed out while the message is still open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.host_byte_valid |-> out_o.parse_status == s5cp_pkg::StatusMore)
    else $error("host byte reported together with a final status");

  // A complete message is never shorter than the smallest legal one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.parse_status == s5cp_pkg::StatusComplete
      |-> out_o.message_length >= s5cp_pkg::MinMessageLength)
    else $error("complete message with impossible length");

  // A new result is only loaded when a byte was waiting in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid && !out_o.ready |=> $stable(out_o.valid))
    else $error("result register changed without a byte to process");
`endif

endmodule
